@@ design/mmdu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mmdu_pkg;

  localparam int unsigned DataW     = 64;
  localparam int unsigned HalfW     = 32;
  localparam int unsigned CmdW      = 4;
  localparam int unsigned InTdataW  = 136;  // 4 + 64 + 64 = 132, padded to whole bytes
  localparam int unsigned OutTdataW = 192;  // 3 x 64
  localparam int unsigned StepCntW  = 6;    // 64 radix-2 steps

  typedef enum logic [CmdW-1:0] {
    CMD_MULT   = 4'd0,
    CMD_MULTU  = 4'd1,
    CMD_DIV    = 4'd2,
    CMD_DIVU   = 4'd3,
    CMD_DMULT  = 4'd4,
    CMD_DMULTU = 4'd5,
    CMD_DDIV   = 4'd6,
    CMD_DDIVU  = 4'd7,
    CMD_MTHI   = 4'd8,
    CMD_MTLO   = 4'd9,
    CMD_MFHI   = 4'd10,
    CMD_MFLO   = 4'd11
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP_A,
    ST_PREP_B,
    ST_RUN,
    ST_FIX_A,
    ST_FIX_B,
    ST_DONE
  } state_e;

  function automatic logic [DataW-1:0] sext32(input logic [HalfW-1:0] v);
    return {{(DataW-HalfW){v[HalfW-1]}}, v};
  endfunction

  function automatic logic [DataW-1:0] zext32(input logic [HalfW-1:0] v);
    return {{(DataW-HalfW){1'b0}}, v};
  endfunction

endpackage

`default_nettype wire

@@ design/mips64_multiply_divide_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A multiply or divide request passes the sign-prep states PREP_A and PREP_B, 64 radix-2
// steps of the shared 65-bit add/subtract unit, the sign-fix states FIX_A and FIX_B and the
// commit state; a move-to or move-from request goes straight to the commit state.
// A new request is taken only once the last one has committed, and also while a finished result
// still waits in the output register; its commit holds until that register is free.
// Reset: asynchronous, active low; clears HI, LO, the sequencer and the output valid.

module mips64_multiply_divide_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // command [3:0], operand_a [67:4], operand_b [131:68], zero pad [135:132]
  input  wire logic [mmdu_pkg::InTdataW-1:0]      s_axis_tdata,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // read_data [63:0], hi_after [127:64], lo_after [191:128]
  output logic [mmdu_pkg::OutTdataW-1:0]          m_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready
);

  localparam int unsigned DataW = mmdu_pkg::DataW;
  localparam int unsigned HalfW = mmdu_pkg::HalfW;
  localparam int unsigned CmdW  = mmdu_pkg::CmdW;

  // Unpack the request.
  mmdu_pkg::cmd_e   in_cmd;
  logic [DataW-1:0] in_a;
  logic [DataW-1:0] in_b;

  assign in_cmd = mmdu_pkg::cmd_e'(s_axis_tdata[CmdW-1:0]);
  assign in_a   = s_axis_tdata[CmdW +: DataW];
  assign in_b   = s_axis_tdata[CmdW+DataW +: DataW];

  // Sequencer and datapath registers.
  mmdu_pkg::state_e state_q, state_d;
  mmdu_pkg::cmd_e   cmd_q, cmd_d;
  logic [mmdu_pkg::StepCntW-1:0] cnt_q, cnt_d;
  logic             is_div_q, is_div_d;
  logic             neg_a_q, neg_a_d;      // operand a negative and needs sign handling
  logic             neg_b_q, neg_b_d;
  logic [DataW-1:0] opa_q, opa_d;          // multiplicand, or value for a move-to
  logic [DataW-1:0] opb_q, opb_d;          // multiplier copy, or divisor magnitude
  logic [DataW-1:0] acc_q, acc_d;          // product high half, or partial remainder
  logic [DataW-1:0] shr_q, shr_d;          // multiplier bits / product low half, or quotient
  logic [DataW-1:0] hi_q, hi_d;
  logic [DataW-1:0] lo_q, lo_d;

  // Output register.
  logic             ovalid_q, ovalid_d;
  logic [DataW-1:0] ord_q, ord_d;
  logic [DataW-1:0] ohi_q, ohi_d;
  logic [DataW-1:0] olo_q, olo_d;

  // The one shared add/subtract unit: sum = x + y, or x - y with the borrow-free carry in bit 65.
  logic [DataW:0]   add_x;
  logic [DataW:0]   add_y;
  logic             add_sub;
  logic [DataW+1:0] add_sum;

  assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(DataW+1){add_sub}}}
                 + {{(DataW+1){1'b0}}, add_sub};

  assign s_axis_tready = (state_q == mmdu_pkg::ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {olo_q, ohi_q, ord_q};

  // Locals of the next-state block.
  logic [DataW-1:0] a_ext;
  logic [DataW-1:0] b_ext;
  logic             in_div;
  logic             in_arith;
  logic             in_signed;
  logic             quo_ge;
  logic [DataW:0]   mul_part;
  logic [DataW-1:0] new_hi;
  logic [DataW-1:0] new_lo;
  logic [DataW-1:0] new_rd;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    is_div_d  = is_div_q;
    neg_a_d   = neg_a_q;
    neg_b_d   = neg_b_q;
    opa_d     = opa_q;
    opb_d     = opb_q;
    acc_d     = acc_q;
    shr_d     = shr_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    ovalid_d  = ovalid_q;
    ord_d     = ord_q;
    ohi_d     = ohi_q;
    olo_d     = olo_q;
    add_x     = '0;
    add_y     = '0;
    add_sub   = 1'b1;
    a_ext     = in_a;
    b_ext     = in_b;
    in_div    = 1'b0;
    in_arith  = 1'b1;
    in_signed = 1'b0;
    quo_ge    = 1'b0;
    mul_part  = '0;
    new_hi    = hi_q;
    new_lo    = lo_q;
    new_rd    = '0;

    // Drop the result once the consumer takes it.
    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    // Operand conditioning for a fresh request.
    case (in_cmd)
      mmdu_pkg::CMD_MULT: begin
        // Sign-extended operands make the low 64 bits of the unsigned product the signed one.
        a_ext = mmdu_pkg::sext32(in_a[HalfW-1:0]);
        b_ext = mmdu_pkg::sext32(in_b[HalfW-1:0]);
      end
      mmdu_pkg::CMD_MULTU: begin
        a_ext = mmdu_pkg::zext32(in_a[HalfW-1:0]);
        b_ext = mmdu_pkg::zext32(in_b[HalfW-1:0]);
      end
      mmdu_pkg::CMD_DIV: begin
        a_ext     = mmdu_pkg::sext32(in_a[HalfW-1:0]);
        b_ext     = mmdu_pkg::sext32(in_b[HalfW-1:0]);
        in_div    = 1'b1;
        in_signed = 1'b1;
      end
      mmdu_pkg::CMD_DIVU: begin
        a_ext  = mmdu_pkg::zext32(in_a[HalfW-1:0]);
        b_ext  = mmdu_pkg::zext32(in_b[HalfW-1:0]);
        in_div = 1'b1;
      end
      mmdu_pkg::CMD_DMULT: begin
        in_signed = 1'b1;
      end
      mmdu_pkg::CMD_DMULTU: begin
        in_signed = 1'b0;
      end
      mmdu_pkg::CMD_DDIV: begin
        in_div    = 1'b1;
        in_signed = 1'b1;
      end
      mmdu_pkg::CMD_DDIVU: begin
        in_div = 1'b1;
      end
      default: begin
        in_arith = 1'b0;
      end
    endcase

    case (state_q)
      mmdu_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d    = in_cmd;
          is_div_d = in_div;
          neg_a_d  = in_signed & a_ext[DataW-1];
          neg_b_d  = in_signed & b_ext[DataW-1];
          opa_d    = a_ext;
          opb_d    = b_ext;
          acc_d    = '0;
          shr_d    = in_div ? a_ext : b_ext;
          state_d  = in_arith ? mmdu_pkg::ST_PREP_A : mmdu_pkg::ST_DONE;
        end
      end
      mmdu_pkg::ST_PREP_A: begin
        // Take the dividend magnitude.
        add_y = {1'b0, shr_q};
        if (is_div_q && neg_a_q) begin
          shr_d = add_sum[DataW-1:0];
        end
        state_d = mmdu_pkg::ST_PREP_B;
      end
      mmdu_pkg::ST_PREP_B: begin
        // Take the divisor magnitude.
        add_y = {1'b0, opb_q};
        if (is_div_q && neg_b_q) begin
          opb_d = add_sum[DataW-1:0];
        end
        cnt_d   = '0;
        state_d = mmdu_pkg::ST_RUN;
      end
      mmdu_pkg::ST_RUN: begin
        if (is_div_q) begin
          // Restoring step: shift in the next dividend bit, keep the difference if no borrow.
          add_x  = {acc_q, shr_q[DataW-1]};
          add_y  = {1'b0, opb_q};
          quo_ge = add_sum[DataW+1];
          acc_d  = quo_ge ? add_sum[DataW-1:0] : add_x[DataW-1:0];
          shr_d  = {shr_q[DataW-2:0], quo_ge};
        end else begin
          // Shift-add step: add the multiplicand on a set multiplier bit, shift right.
          add_x    = {1'b0, acc_q};
          add_y    = {1'b0, opa_q};
          add_sub  = 1'b0;
          mul_part = shr_q[0] ? add_sum[DataW:0] : add_x;
          acc_d    = mul_part[DataW:1];
          shr_d    = {mul_part[0], shr_q[DataW-1:1]};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = mmdu_pkg::ST_FIX_A;
        end
      end
      mmdu_pkg::ST_FIX_A: begin
        if (is_div_q) begin
          // Quotient is negative when the signs differ.
          add_y = {1'b0, shr_q};
          if (neg_a_q ^ neg_b_q) begin
            shr_d = add_sum[DataW-1:0];
          end
        end else begin
          // Signed high half: subtract b when a is negative.
          add_x = {1'b0, acc_q};
          add_y = {1'b0, opb_q};
          if (neg_a_q) begin
            acc_d = add_sum[DataW-1:0];
          end
        end
        state_d = mmdu_pkg::ST_FIX_B;
      end
      mmdu_pkg::ST_FIX_B: begin
        if (is_div_q) begin
          // Remainder takes the sign of the dividend.
          add_y = {1'b0, acc_q};
          if (neg_a_q) begin
            acc_d = add_sum[DataW-1:0];
          end
        end else begin
          // Signed high half: subtract a when b is negative.
          add_x = {1'b0, acc_q};
          add_y = {1'b0, opa_q};
          if (neg_b_q) begin
            acc_d = add_sum[DataW-1:0];
          end
        end
        state_d = mmdu_pkg::ST_DONE;
      end
      mmdu_pkg::ST_DONE: begin
        case (cmd_q)
          mmdu_pkg::CMD_MULT, mmdu_pkg::CMD_MULTU: begin
            new_hi = mmdu_pkg::sext32(shr_q[DataW-1:HalfW]);
            new_lo = mmdu_pkg::sext32(shr_q[HalfW-1:0]);
          end
          mmdu_pkg::CMD_DIV, mmdu_pkg::CMD_DIVU: begin
            new_hi = mmdu_pkg::sext32(acc_q[HalfW-1:0]);
            new_lo = mmdu_pkg::sext32(shr_q[HalfW-1:0]);
          end
          mmdu_pkg::CMD_DMULT, mmdu_pkg::CMD_DMULTU,
          mmdu_pkg::CMD_DDIV, mmdu_pkg::CMD_DDIVU: begin
            new_hi = acc_q;
            new_lo = shr_q;
          end
          mmdu_pkg::CMD_MTHI: begin
            new_hi = opa_q;
          end
          mmdu_pkg::CMD_MTLO: begin
            new_lo = opa_q;
          end
          mmdu_pkg::CMD_MFHI: begin
            new_rd = hi_q;
          end
          mmdu_pkg::CMD_MFLO: begin
            new_rd = lo_q;
          end
          default: begin
            new_rd = '0;
          end
        endcase
        // Commit HI/LO and the result together once the output register is free.
        if (!ovalid_q || m_axis_tready) begin
          hi_d     = new_hi;
          lo_d     = new_lo;
          ord_d    = new_rd;
          ohi_d    = new_hi;
          olo_d    = new_lo;
          ovalid_d = 1'b1;
          state_d  = mmdu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mmdu_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mmdu_pkg::ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      hi_q     <= '0;
      lo_q     <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      hi_q     <= hi_d;
      lo_q     <= lo_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    is_div_q <= is_div_d;
    neg_a_q  <= neg_a_d;
    neg_b_q  <= neg_b_d;
    opa_q    <= opa_d;
    opb_q    <= opb_d;
    acc_q    <= acc_d;
    shr_q    <= shr_d;
    ord_q    <= ord_d;
    ohi_q    <= ohi_d;
    olo_q    <= olo_d;
  end

  // A result only ever appears out of the commit state.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == mmdu_pkg::ST_DONE))
    else $error("result raised outside the commit state");

  // The iteration loop runs all 64 steps before the sign fix-up.
  a_full_iteration: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mmdu_pkg::ST_RUN && state_d != mmdu_pkg::ST_RUN) |-> cnt_q == '1)
    else $error("iteration loop left early");

  // HI and LO change only at commit, and the result shows the committed values.
  a_hilo_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$stable(hi_q) || !$stable(lo_q)) |->
      ($past(state_q == mmdu_pkg::ST_DONE) && ohi_q == hi_q && olo_q == lo_q))
    else $error("HI/LO updated outside commit");

endmodule

`default_nettype wire
